@@ rtl/resm_pkg.sv @@
// Shared types, constants and register codes of the redundant e-stop multiplexer monitor.
`timescale 1ns / 1ps

package resm_pkg;

  localparam int MUX_CHANNELS = 8;
  localparam int LOOP_COUNT   = 4;
  localparam int SAMPLE_BITS  = 12;
  localparam int SEL_BITS     = 3;
  localparam int CHAN_BITS    = 4;
  localparam int NUM_REGS     = 4;
  localparam int PADDR_BITS   = $clog2(4 * NUM_REGS);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
  localparam logic [10:0] NOSNAP_STEP = 11'd2;
  localparam logic [10:0] NOSNAP_MAX  = 11'd2047;

  localparam logic [10:0] TOLERANCE_RESET = 11'd256;
  localparam logic [9:0]  DEBOUNCE_RESET  = 10'd500;
  localparam logic [15:0] SUPPRESS_RESET  = 16'd500;
  localparam logic [10:0] NOSNAP_RESET    = 11'd100;

  typedef enum logic [1:0] {
    REG_TOLERANCE = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_SUPPRESS  = 2'd2,
    REG_NOSNAP    = 2'd3
  } reg_idx_e;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [10:0] redund_tolerance;
    logic [9:0]  debounce_len;
    logic [15:0] suppress_window_ms;
    logic [10:0] nosnap_limit_ms;
  } cfg_t;

  typedef struct packed {
    logic                 snapshot_valid;
    logic [CHAN_BITS-1:0] mux_channel;
    sample_t              mux_sample;
    logic                 estop_pressed;
    logic [31:0]          now_ms;
  } in_word_t;

  typedef struct packed {
    logic [LOOP_COUNT-1:0] closed_mask;
    logic                  monitor_valid;
    logic [LOOP_COUNT-1:0] fault_report;
    logic [SEL_BITS-1:0]   next_mux_select;
    logic                  link_recover;
  } out_word_t;

endpackage

@@ rtl/resm_apb_regs.sv @@
// APB configuration registers of the e-stop multiplexer monitor.
`timescale 1ns / 1ps

module resm_apb_regs
  import resm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.redund_tolerance   <= TOLERANCE_RESET;
      cfg_q.debounce_len       <= DEBOUNCE_RESET;
      cfg_q.suppress_window_ms <= SUPPRESS_RESET;
      cfg_q.nosnap_limit_ms    <= NOSNAP_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TOLERANCE: cfg_q.redund_tolerance   <= pwdata[10:0];
        REG_DEBOUNCE:  cfg_q.debounce_len       <= pwdata[9:0];
        REG_SUPPRESS:  cfg_q.suppress_window_ms <= pwdata[15:0];
        REG_NOSNAP:    cfg_q.nosnap_limit_ms    <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TOLERANCE: prdata = {21'd0, cfg_q.redund_tolerance};
      REG_DEBOUNCE:  prdata = {22'd0, cfg_q.debounce_len};
      REG_SUPPRESS:  prdata = {16'd0, cfg_q.suppress_window_ms};
      REG_NOSNAP:    prdata = {21'd0, cfg_q.nosnap_limit_ms};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/resm_diag.sv @@
// Loop node comparison, e-stop suppression and per-loop debounce counters.
`timescale 1ns / 1ps

module resm_diag
  import resm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  run_i,
  input  logic                  estop_i,
  input  logic [31:0]           now_i,
  input  sample_t               samples_i [MUX_CHANNELS],
  input  cfg_t                  cfg_i,
  output logic [LOOP_COUNT-1:0] closed_o,
  output logic [LOOP_COUNT-1:0] report_o
);

  logic [9:0]  count_q [LOOP_COUNT];
  logic [9:0]  count_d [LOOP_COUNT];
  logic        prev_estop_q, prev_estop_d;
  logic [31:0] last_edge_q, last_edge_d;
  logic [31:0] edge_ms;
  logic [31:0] elapsed;
  logic        suppress;
  sample_t     node_a [LOOP_COUNT];
  sample_t     node_b [LOOP_COUNT];
  sample_t     diff   [LOOP_COUNT];
  logic [LOOP_COUNT-1:0] normal;

  always_comb begin
    edge_ms  = (estop_i != prev_estop_q) ? now_i : last_edge_q;
    elapsed  = now_i - edge_ms;
    suppress = estop_i || (elapsed < {16'd0, cfg_i.suppress_window_ms});

    prev_estop_d = run_i ? estop_i : prev_estop_q;
    last_edge_d  = run_i ? edge_ms : last_edge_q;

    for (int i = 0; i < LOOP_COUNT; i++) begin
      node_a[i] = (2 * i < MUX_CHANNELS) ? samples_i[2 * i] : '0;
      node_b[i] = (2 * i + 1 < MUX_CHANNELS) ? samples_i[2 * i + 1] : '0;
      diff[i]   = (node_a[i] >= node_b[i]) ? (node_a[i] - node_b[i])
                                           : (node_b[i] - node_a[i]);
      closed_o[i] = {1'b0, diff[i]} <= {2'b00, cfg_i.redund_tolerance};
      // complementary nodes: difference within tolerance of full scale
      normal[i]   = closed_o[i] ||
                    (({1'b0, diff[i]} + {2'b00, cfg_i.redund_tolerance}) >=
                     {1'b0, FULL_SCALE});

      count_d[i]  = count_q[i];
      report_o[i] = 1'b0;
      if (run_i) begin
        if (suppress || normal[i]) begin
          count_d[i] = '0;
        end else if (count_q[i] < cfg_i.debounce_len) begin
          count_d[i]  = count_q[i] + 10'd1;
          report_o[i] = count_d[i] >= cfg_i.debounce_len;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_estop_q <= 1'b0;
      last_edge_q  <= '0;
      for (int i = 0; i < LOOP_COUNT; i++) count_q[i] <= '0;
    end else begin
      prev_estop_q <= prev_estop_d;
      last_edge_q  <= last_edge_d;
      for (int i = 0; i < LOOP_COUNT; i++) count_q[i] <= count_d[i];
    end
  end

endmodule

@@ rtl/redundant_estop_mux_monitor.sv @@
// Top level of the redundant e-stop multiplexer monitor.
`timescale 1ns / 1ps

// One input word per sample period, one result word per input word. The
// block takes a word in every cycle while in_ready_o is high; each word goes
// through the input register, then the result register. The result holds
// while out_ready_i is low, and one more word waits in the input register
// meanwhile; in_ready_o drops only when both are full. A snapshot with a
// channel tag below eight lands in the sample store and marks the channel
// ready; any valid snapshot steps the preselect. Once all eight channels
// are ready, each loop's even and odd nodes are compared, and a mismatch
// that is neither consistent nor complementary counts toward a debounce
// that reports once. Periods without a snapshot advance the recovery
// watchdog by 2 ms. Registers sit on APB at 0x0 tolerance, 0x4 debounce,
// 0x8 suppress window, 0xC watchdog limit; write them only while idle.

module redundant_estop_mux_monitor
  import resm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_word_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  cfg_t cfg;

  // pipeline control
  logic      s1_valid_q;
  in_word_t  s1_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t out_word_d;
  logic      s1_adv;
  logic      in_fire;
  logic      proc;

  // block state
  sample_t                 samples_q [MUX_CHANNELS];
  sample_t                 samples_d [MUX_CHANNELS];
  logic [MUX_CHANNELS-1:0] ready_q, ready_d;
  logic [SEL_BITS-1:0]     sel_q, sel_d;
  logic [10:0]             nosnap_q, nosnap_d;
  logic [11:0]             nosnap_sum;
  logic [10:0]             nosnap_t;
  logic                    recover;
  logic                    all_ready;
  logic                    diag_run;
  logic [LOOP_COUNT-1:0]   closed;
  logic [LOOP_COUNT-1:0]   report;

  resm_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // the word in the input register is processed when the result register frees
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;
  assign proc       = s1_valid_q && s1_adv;

  always_comb begin
    samples_d  = samples_q;
    ready_d    = ready_q;
    sel_d      = sel_q;
    recover    = 1'b0;
    nosnap_sum = {1'b0, nosnap_q} + {1'b0, NOSNAP_STEP};
    nosnap_t   = (nosnap_sum > {1'b0, NOSNAP_MAX}) ? NOSNAP_MAX : nosnap_sum[10:0];
    nosnap_d   = nosnap_q;

    if (!s1_word_q.snapshot_valid) begin
      // watchdog: missing snapshot, pulse recovery at the limit
      if (nosnap_t >= cfg.nosnap_limit_ms) begin
        nosnap_d = '0;
        recover  = 1'b1;
      end else begin
        nosnap_d = nosnap_t;
      end
    end else begin
      nosnap_d = '0;
      if ({1'b0, s1_word_q.mux_channel} < (CHAN_BITS + 1)'(MUX_CHANNELS)) begin
        samples_d[s1_word_q.mux_channel[SEL_BITS-1:0]] = s1_word_q.mux_sample;
        ready_d[s1_word_q.mux_channel[SEL_BITS-1:0]]   = 1'b1;
      end
      sel_d = (sel_q == SEL_BITS'(MUX_CHANNELS - 1)) ? '0 : sel_q + 1'b1;
    end
  end

  assign all_ready = &ready_d;
  assign diag_run  = proc && s1_word_q.snapshot_valid && all_ready;

  resm_diag u_diag (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .run_i     (diag_run),
    .estop_i   (s1_word_q.estop_pressed),
    .now_i     (s1_word_q.now_ms),
    .samples_i (samples_d),
    .cfg_i     (cfg),
    .closed_o  (closed),
    .report_o  (report)
  );

  always_comb begin
    out_word_d.closed_mask     = closed;
    out_word_d.monitor_valid   = all_ready;
    out_word_d.fault_report    = report;
    out_word_d.next_mux_select = sel_d;
    out_word_d.link_recover    = recover;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ready_q     <= '0;
      sel_q       <= '0;
      nosnap_q    <= '0;
      for (int i = 0; i < MUX_CHANNELS; i++) samples_q[i] <= '0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_adv)     out_valid_q <= s1_valid_q;
      if (proc) begin
        ready_q  <= ready_d;
        sel_q    <= sel_d;
        nosnap_q <= nosnap_d;
        for (int i = 0; i < MUX_CHANNELS; i++) samples_q[i] <= samples_d[i];
      end
    end
  end

  // payload words, no reset
  always_ff @(posedge clk_i) begin
    if (in_fire) s1_word_q  <= in_data_i;
    if (proc)    out_word_q <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // stall only with both registers full and the result not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // a full ready mask never loses a channel
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&ready_q) |=> (&ready_q))
    else $error("ready mask cleared");

  // a fault report needs a valid monitor and a snapshot period
  a_report_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.fault_report != '0)) |->
      (out_data_o.monitor_valid && !out_data_o.link_recover))
    else $error("fault report outside diagnosis");

  // recovery pulse only for a period without snapshot
  a_recover_nosnap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && recover) |-> !s1_word_q.snapshot_valid)
    else $error("link recovery on a snapshot period");

endmodule
